// File: src/esma_pkg.sv
// Package with shared types and constants of the encoder speed moving average.
`default_nettype none
package esma_pkg;

  // Field widths of the input and result items
  localparam int POS_W   = 32;
  localparam int TICK_W  = 32;
  localparam int SPEED_W = 16;

  // Speed scale of 1024 is a left shift by 10
  localparam int SPEED_SHIFT = 10;

  // Quotient bits produced for the speed division, one per cycle
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_WRB,
    ST_AVGP,
    ST_AVG,
    ST_FIN
  } esma_state_t;

endpackage
`default_nettype wire

// File: src/esma_in_if.sv
// Input channel interface: encoder position and tick count item.
`default_nettype none
interface esma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [esma_pkg::POS_W-1:0]   position;
  logic        [esma_pkg::TICK_W-1:0]  tick_count;

  modport source (output valid, output position, output tick_count, input ready);
  modport sink   (input valid, input position, input tick_count, output ready);
endinterface
`default_nettype wire

// File: src/esma_out_if.sv
// Result channel interface: average speed, instant speed and zero interval flag.
`default_nettype none
interface esma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [esma_pkg::SPEED_W-1:0]  average_speed;
  logic signed [esma_pkg::SPEED_W-1:0]  instant_speed;
  logic                                 zero_interval;

  modport source (output valid, output average_speed, output instant_speed,
                  output zero_interval, input ready);
  modport sink   (input valid, input average_speed, input instant_speed,
                  input zero_interval, output ready);
endinterface
`default_nettype wire

// File: src/encoder_speed_moving_average.sv
// Encoder speed estimator with a moving-average filter over recent speed samples.
//
// Usage: in_chan (valid/ready) carries position and tick_count. For each accepted
// item one result leaves on out_chan: the new speed sample
// (delta position * 1024 / delta ticks, truncated toward zero, wrapped to 16 bits),
// the mean of the last HISTORY_DEPTH samples (truncated toward zero) and a flag
// set when the tick delta was zero (sample forced to 0).
// After accept the sequencer steps through PREP, DIV, WRB, AVGP, AVG and FIN;
// the next item is accepted only once it is back in IDLE. The bit-serial
// restoring divider is run once for the speed quotient (32 steps) and once for
// the mean (SUMW steps), with SUMW = 16 + clog2(HISTORY_DEPTH).
// in_chan.ready is high only while the sequencer is idle; the block accepts the
// next item while a finished result still waits in the output register.
// If the receiver stalls, the next result is held internally until the output
// register frees up. Reset (rst_n low, synchronous) clears the last position,
// last tick, the speed ring, the ring index and the output valid.
`default_nettype none
module encoder_speed_moving_average #(
  parameter int HISTORY_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  esma_in_if.sink    in_chan,
  esma_out_if.source out_chan
);

  localparam int IW   = $clog2(HISTORY_DEPTH);
  localparam int RW   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW = esma_pkg::SPEED_W + $clog2(HISTORY_DEPTH);
  localparam int SW   = esma_pkg::SPEED_W;
  localparam int CW   = esma_pkg::CNT_W;

  esma_pkg::esma_state_t state_r, state_nxt;

  // Divider registers
  logic [31:0]     dvd_r;
  logic [31:0]     dvs_r;
  logic [31:0]     rem_r;
  logic [SW-1:0]   quo_r;
  logic [CW-1:0]   cnt_r;
  logic            neg_r;
  logic            zero_r;

  // History state
  logic [31:0]     last_pos_r;
  logic [31:0]     last_tick_r;
  logic [SW-1:0]   ring_r [HISTORY_DEPTH];
  logic [IW-1:0]   slot_r;
  logic [RW-1:0]   rd_idx_r;
  logic [SUMW-1:0] acc_r;
  logic [SW-1:0]   inst_r;

  // Output register
  logic            out_valid_r;
  logic [SW-1:0]   out_avg_r;
  logic [SW-1:0]   out_inst_r;
  logic            out_zero_r;

  logic            in_fire;
  logic            out_load;
  logic [31:0]     rem_sh;
  logic [32:0]     trial;
  logic            fits;
  logic [SW-1:0]   sample;
  logic [SW-1:0]   ring_rd;
  logic [SUMW-1:0] acc_mag;

  assign in_fire = in_chan.valid && in_chan.ready;

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_r[30:0], dvd_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign fits   = ~trial[32];

  // Signed speed sample from the magnitude quotient
  assign sample = zero_r ? '0 : (neg_r ? (~quo_r + 1'b1) : quo_r);

  // Ring read for the running sum
  assign ring_rd = ring_r[rd_idx_r[IW-1:0]];

  // Magnitude of the ring sum
  assign acc_mag = acc_r[SUMW-1] ? (~acc_r + 1'b1) : acc_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake controls
  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      esma_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) state_nxt = esma_pkg::ST_PREP;
      end
      esma_pkg::ST_PREP: state_nxt = esma_pkg::ST_DIV;
      esma_pkg::ST_DIV: begin
        if (cnt_r == '0) state_nxt = esma_pkg::ST_WRB;
      end
      esma_pkg::ST_WRB:  state_nxt = esma_pkg::ST_AVGP;
      esma_pkg::ST_AVGP: state_nxt = esma_pkg::ST_AVG;
      esma_pkg::ST_AVG: begin
        if (cnt_r == '0) state_nxt = esma_pkg::ST_FIN;
      end
      esma_pkg::ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = esma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = esma_pkg::ST_IDLE;
    endcase
  end

  // History state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r  <= '0;
      last_tick_r <= '0;
      slot_r      <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring_r[i] <= '0;
    end else begin
      if (in_fire) begin
        last_pos_r  <= in_chan.position;
        last_tick_r <= in_chan.tick_count;
      end
      if (state_r == esma_pkg::ST_WRB) begin
        ring_r[slot_r] <= sample;
        slot_r <= (slot_r == IW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // Divider and accumulator datapath
  always_ff @(posedge clk) begin
    case (state_r)
      esma_pkg::ST_IDLE: begin
        if (in_fire) begin
          dvd_r <= (in_chan.position - last_pos_r) << esma_pkg::SPEED_SHIFT;
          dvs_r <= in_chan.tick_count - last_tick_r;
        end
      end
      esma_pkg::ST_PREP: begin
        zero_r   <= (dvs_r == '0);
        neg_r    <= dvd_r[31] ^ dvs_r[31];
        dvd_r    <= dvd_r[31] ? (~dvd_r + 1'b1) : dvd_r;
        dvs_r    <= dvs_r[31] ? (~dvs_r + 1'b1) : dvs_r;
        rem_r    <= '0;
        quo_r    <= '0;
        cnt_r    <= CW'(esma_pkg::DIV_STEPS - 1);
        rd_idx_r <= '0;
        acc_r    <= '0;
      end
      esma_pkg::ST_DIV: begin
        rem_r <= fits ? trial[31:0] : rem_sh;
        quo_r <= {quo_r[SW-2:0], fits};
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        // sum the entries that stay in the ring, one per cycle
        if (rd_idx_r < RW'(HISTORY_DEPTH)) begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r[IW-1:0] != slot_r) begin
            acc_r <= acc_r + {{(SUMW-SW){ring_rd[SW-1]}}, ring_rd};
          end
        end
      end
      esma_pkg::ST_WRB: begin
        inst_r <= sample;
        acc_r  <= acc_r + {{(SUMW-SW){sample[SW-1]}}, sample};
      end
      esma_pkg::ST_AVGP: begin
        neg_r <= acc_r[SUMW-1];
        dvd_r <= {acc_mag, {(32-SUMW){1'b0}}};
        dvs_r <= 32'(HISTORY_DEPTH);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(SUMW - 1);
      end
      esma_pkg::ST_AVG: begin
        rem_r <= fits ? trial[31:0] : rem_sh;
        quo_r <= {quo_r[SW-2:0], fits};
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r  <= neg_r ? (~quo_r + 1'b1) : quo_r;
      out_inst_r <= inst_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.average_speed = out_avg_r;
  assign out_chan.instant_speed = out_inst_r;
  assign out_chan.zero_interval = out_zero_r;

endmodule
`default_nettype wire

// File: test/encoder_speed_moving_average_tb.sv
// Testbench for the encoder speed estimator with moving-average filter.
`timescale 1ns / 100ps
module encoder_speed_moving_average_tb;

  localparam int DEPTH       = 4;
  localparam int RAND_ITEMS  = 1800;
  localparam int QUIET_TAIL  = 200;
  localparam int DRAIN_WAIT  = 60;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic signed [esma_pkg::SPEED_W-1:0] average_speed;
    logic signed [esma_pkg::SPEED_W-1:0] instant_speed;
    logic                                zero_interval;
  } speed_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  esma_in_if  in_chan ();
  esma_out_if out_chan ();

  encoder_speed_moving_average #(.HISTORY_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors what the block keeps between items
  logic signed [esma_pkg::POS_W-1:0]   est_last_pos;
  logic        [esma_pkg::TICK_W-1:0]  est_last_tick;
  logic signed [esma_pkg::SPEED_W-1:0] est_ring [DEPTH];
  int                                  est_slot;

  speed_result_t speed_q[$];
  int  error_count   = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  zero_seen     = 0;
  int  stall_left    = 0;
  int  idle_cycles   = 0;
  bit  src_gaps      = 1'b1;
  bit  sink_gaps     = 1'b1;

  // Speed sample and ring mean for one item; advances the predictor state
  function automatic speed_result_t estimate_speed(
      input logic signed [esma_pkg::POS_W-1:0] pos,
      input logic [esma_pkg::TICK_W-1:0] tick);
    logic [esma_pkg::POS_W-1:0]  dpos;
    logic [esma_pkg::POS_W-1:0]  scaled;
    logic [esma_pkg::TICK_W-1:0] dtick;
    longint                      quo;
    longint                      sum;
    speed_result_t               r;
    dpos   = pos - est_last_pos;
    scaled = dpos << esma_pkg::SPEED_SHIFT;
    dtick  = tick - est_last_tick;
    r.zero_interval = (dtick == '0);
    if (r.zero_interval) begin
      r.instant_speed = '0;
    end else begin
      quo = longint'($signed(scaled)) / longint'($signed(dtick));
      r.instant_speed = quo[esma_pkg::SPEED_W-1:0];
    end
    est_ring[est_slot] = r.instant_speed;
    est_slot = (est_slot + 1) % DEPTH;
    est_last_pos  = pos;
    est_last_tick = tick;
    sum = 0;
    for (int i = 0; i < DEPTH; i++) sum += longint'(est_ring[i]);
    quo = sum / DEPTH;
    r.average_speed = quo[esma_pkg::SPEED_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
             $realtime, results_seen, what, got, want);
  endtask

  // Offer one item and wait until it is taken; valid stays high afterwards
  task automatic send_sample(input logic signed [esma_pkg::POS_W-1:0] pos,
                             input logic [esma_pkg::TICK_W-1:0] tick);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.position   <= pos;
    in_chan.tick_count <= tick;
    do @(posedge clk); while (!in_chan.ready);
    speed_q.push_back(estimate_speed(pos, tick));
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    speed_result_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.zero_interval) zero_seen++;
      if (speed_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_chan.average_speed, 0);
      end else begin
        exp_r = speed_q.pop_front();
        if (out_chan.average_speed !== exp_r.average_speed)
          report_mismatch("average_speed", out_chan.average_speed, exp_r.average_speed);
        if (out_chan.instant_speed !== exp_r.instant_speed)
          report_mismatch("instant_speed", out_chan.instant_speed, exp_r.instant_speed);
        if (out_chan.zero_interval !== exp_r.zero_interval)
          report_mismatch("zero_interval", out_chan.zero_interval, exp_r.zero_interval);
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9);
    end
    out_chan.ready <= (stall_left == 0);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("FAIL encoder_speed_moving_average");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // State right after reset: zero deltas against cleared registers
  task automatic test_reset_state();
    send_sample(32'sd0, 32'd0);
    send_sample(32'sd100, 32'd0);
    send_sample(32'sd100, 32'd1024);
    send_sample(32'sd1124, 32'd2048);
  endtask

  // Field extremes, tick wrap and a backward tick jump
  task automatic test_field_extremes();
    send_sample(32'sh7FFFFFFF, 32'hFFFFFFFF);
    send_sample(32'sh80000000, 32'h00000000);
    send_sample(-32'sd1, 32'h7FFFFFFF);
    send_sample(32'sd0, 32'hFFFFFFF0);
    send_sample(32'sd5, 32'h00000010);
  endtask

  // Most negative product over -1, and quotients beyond 16 bits
  task automatic test_quotient_wrap();
    send_sample(32'sd0, 32'd5);
    send_sample(32'sh00200000, 32'd4);
    send_sample(32'sh00200000 + 32'sd1000, 32'd5);
    send_sample(32'sh00200000 - 32'sd2000, 32'd6);
  endtask

  // Ring index wrap and mean truncated toward zero for negative sums
  task automatic test_ring_truncation();
    send_sample(32'sd0, 32'd1000);
    send_sample(32'sd0, 32'd2000);
    send_sample(32'sd0, 32'd3000);
    send_sample(32'sd0, 32'd4000);
    send_sample(-32'sd1, 32'd5024);
    send_sample(-32'sd2, 32'd5536);
    send_sample(-32'sd6, 32'd6560);
    send_sample(-32'sd6, 32'd7584);
  endtask

  // Mostly plausible motion, with repeated ticks, noise and extremes
  task automatic send_random_sample();
    int                                 kind;
    logic signed [esma_pkg::POS_W-1:0]  pos;
    logic        [esma_pkg::TICK_W-1:0] tick;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      pos  = est_last_pos + $signed($urandom_range(0, 4000)) - 32'sd2000;
      tick = est_last_tick + $urandom_range(1, 5000);
    end else if (kind < 78) begin
      pos  = est_last_pos + $signed($urandom_range(0, 400)) - 32'sd200;
      tick = est_last_tick;
    end else if (kind < 90) begin
      pos  = $urandom;
      tick = $urandom;
    end else if (kind < 95) begin
      case ($urandom_range(0, 3))
        0: pos = 32'sh7FFFFFFF;
        1: pos = 32'sh80000000;
        2: pos = 32'sd0;
        default: pos = -32'sd1;
      endcase
      case ($urandom_range(0, 3))
        0: tick = 32'h00000000;
        1: tick = 32'hFFFFFFFF;
        2: tick = est_last_tick - 32'd1;
        default: tick = est_last_tick + 32'd1;
      endcase
    end else begin
      pos  = est_last_pos + $signed($urandom);
      tick = est_last_tick + $urandom_range(1, 3);
    end
    send_sample(pos, tick);
  endtask

  // Sender holds off until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    repeat (12) send_random_sample();
    drain_results();
    repeat (12) send_random_sample();
  endtask

  // Long random run, idling changes every few dozen items, quiet tail
  task automatic test_random_traffic();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i >= RAND_ITEMS - QUIET_TAIL) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end else if (i % 50 == 0) begin
        src_gaps  = ($urandom_range(0, 3) != 0);
        sink_gaps = ($urandom_range(0, 3) != 0);
      end
      send_random_sample();
    end
  endtask

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.position   = '0;
    in_chan.tick_count = '0;
    est_last_pos  = '0;
    est_last_tick = '0;
    est_slot      = 0;
    for (int i = 0; i < DEPTH; i++) est_ring[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_quotient_wrap();
    test_ring_truncation();
    test_drain_pause();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d items and %0d results, %0d of them with a zero tick interval",
             items_sent, results_seen, zero_seen);
    $display("directed: reset state, extremes, quotient wrap, ring truncation; "
             , "random motion with stalls and a drain pause");
    if (error_count == 0) begin
      $display("PASS encoder_speed_moving_average");
    end else begin
      $display("FAIL encoder_speed_moving_average");
    end
    $finish;
  end

endmodule
